[design/lcrs_pkg.sv]
// Shared constants and types for the Life row stepper.
package lcrs_pkg;

  localparam int ROW_W = 64;
  localparam int COLS_W = 7;
  localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [CNT_W-1:0] STAY_COUNT = 4'd2;

  typedef struct packed {
    logic valid;
    logic frame_end;
  } push_ctl_t;

endpackage

[design/lcrs_in_if.sv]
// Input row channel: one grid row per beat.
interface lcrs_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcrs_pkg::ROW_W-1:0]  row_cells;
  logic                        final_row;

  modport source (output valid, output row_cells, output final_row, input ready);
  modport sink (input valid, input row_cells, input final_row, output ready);
endinterface

[design/lcrs_out_if.sv]
// Result channel: one next-generation row per beat.
interface lcrs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcrs_pkg::ROW_W-1:0]  next_row_cells;
  logic                        frame_end;

  modport source (output valid, output next_row_cells, output frame_end, input ready);
  modport sink (input valid, input next_row_cells, input frame_end, output ready);
endinterface

[design/lcrs_front.sv]
// Front end: row window, final-row handling and queue push.
module lcrs_front #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lcrs_in_if.sink                    in_row,
  input  logic                       space,
  output lcrs_pkg::push_ctl_t        push,
  output logic [3*MAX_COLUMNS-1:0]   push_rows
);

  logic [MAX_COLUMNS-1:0] upper_r, upper_nxt;
  logic [MAX_COLUMNS-1:0] middle_r, middle_nxt;
  logic                   held_r, held_nxt;
  logic                   pend_r, pend_nxt;
  logic [MAX_COLUMNS-1:0] row;
  logic                   accept;

  assign row = in_row.row_cells[MAX_COLUMNS-1:0];
  assign in_row.ready = !pend_r && space;
  assign accept = in_row.valid && in_row.ready;

  always_comb begin
    push.valid = (pend_r && space) || (accept && (held_r || in_row.final_row));
    if (pend_r) begin
      push.frame_end = 1'b1;
      push_rows = {upper_r, middle_r, {MAX_COLUMNS{1'b0}}};
    end else if (held_r) begin
      push.frame_end = 1'b0;
      push_rows = {upper_r, middle_r, row};
    end else begin
      push.frame_end = 1'b1;
      push_rows = {{MAX_COLUMNS{1'b0}}, row, {MAX_COLUMNS{1'b0}}};
    end
  end

  always_comb begin
    upper_nxt = upper_r;
    middle_nxt = middle_r;
    held_nxt = held_r;
    pend_nxt = pend_r;
    if (pend_r) begin
      if (space) begin
        upper_nxt = '0;
        middle_nxt = '0;
        pend_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!held_r) begin
        if (!in_row.final_row) begin
          upper_nxt = '0;
          middle_nxt = row;
          held_nxt = 1'b1;
        end
      end else begin
        upper_nxt = middle_r;
        middle_nxt = row;
        if (in_row.final_row) begin
          held_nxt = 1'b0;
          pend_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= '0;
      middle_r <= '0;
      held_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      upper_r <= upper_nxt;
      middle_r <= middle_nxt;
      held_r <= held_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

[design/lcrs_queue.sv]
// Two-entry queue of row windows between front and back.
module lcrs_queue #(
  parameter int WIDTH = 193
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcrs_pkg::push_ctl_t  push,
  input  logic [WIDTH-1:0]     push_rows,
  output logic                 space,
  output lcrs_pkg::push_ctl_t  head,
  output logic [WIDTH-1:0]     head_rows,
  input  logic                 pop
);

  logic [WIDTH-1:0] rows_r [2];
  logic             end_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_pop;

  assign space = (count_r != 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.frame_end = end_r[rd_ptr_r];
  assign head_rows = rows_r[rd_ptr_r];
  assign do_pop = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push.valid;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt = count_r + {1'b0, push.valid} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      rows_r[wr_ptr_r] <= push_rows;
      end_r[wr_ptr_r] <= push.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[design/lcrs_back.sv]
// Back end: B3/S23 stencil over one row window and output register.
module lcrs_back #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lcrs_pkg::COLS_W-1:0]  active_columns,
  input  lcrs_pkg::push_ctl_t          head,
  input  logic [3*MAX_COLUMNS-1:0]     head_rows,
  output logic                         pop,
  lcrs_out_if.source                   out_row
);

  logic [MAX_COLUMNS-1:0] mask;
  logic [MAX_COLUMNS-1:0] above;
  logic [MAX_COLUMNS-1:0] here;
  logic [MAX_COLUMNS-1:0] below;
  logic [MAX_COLUMNS+1:0] pad_a, pad_h, pad_b;
  logic [MAX_COLUMNS-1:0] next_gen;
  logic [lcrs_pkg::CNT_W-1:0] cnt;
  logic [MAX_COLUMNS-1:0] next_row_r;
  logic                   frame_end_r;
  logic                   valid_r, valid_nxt;

  always_comb begin
    for (int x = 0; x < MAX_COLUMNS; x++) begin
      mask[x] = (lcrs_pkg::COLS_W'(x) < active_columns);
    end
    above = head_rows[3*MAX_COLUMNS-1:2*MAX_COLUMNS] & mask;
    here = head_rows[2*MAX_COLUMNS-1:MAX_COLUMNS] & mask;
    below = head_rows[MAX_COLUMNS-1:0] & mask;
    pad_a = {1'b0, above, 1'b0};
    pad_h = {1'b0, here, 1'b0};
    pad_b = {1'b0, below, 1'b0};
    cnt = '0;
    for (int x = 0; x < MAX_COLUMNS; x++) begin
      cnt = lcrs_pkg::CNT_W'(pad_a[x]) + lcrs_pkg::CNT_W'(pad_a[x+1])
          + lcrs_pkg::CNT_W'(pad_a[x+2]) + lcrs_pkg::CNT_W'(pad_h[x])
          + lcrs_pkg::CNT_W'(pad_h[x+2]) + lcrs_pkg::CNT_W'(pad_b[x])
          + lcrs_pkg::CNT_W'(pad_b[x+1]) + lcrs_pkg::CNT_W'(pad_b[x+2]);
      next_gen[x] = mask[x] && ((cnt == lcrs_pkg::BIRTH_COUNT)
                    || (here[x] && (cnt == lcrs_pkg::STAY_COUNT)));
    end
  end

  assign pop = head.valid && (!valid_r || out_row.ready);
  assign valid_nxt = pop || (valid_r && !out_row.ready);

  assign out_row.valid = valid_r;
  assign out_row.next_row_cells = lcrs_pkg::ROW_W'(next_row_r);
  assign out_row.frame_end = frame_end_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      next_row_r <= next_gen;
      frame_end_r <= head.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

[design/life_cellular_automaton_row_step.sv]
// Top level of the Life (B3/S23) row stepper.
// Rows of a grid stream in top to bottom on in_row, one 64-bit row per beat,
// with final_row set on the bottom row. Each row after the first yields the
// next-generation row above it on out_row; the final row also yields its own
// next-generation row with frame_end set, after which the frame state clears.
// A one-row frame yields a single row with frame_end set.
// cfg_data sets the number of active columns (reset 64); higher columns are
// dead and read as zero. Write it only while the block is idle; cfg_ready is
// always high.
// A result passes through the queue and then the output register to out_row.
// The input takes one row per cycle while the queue has space. For a final
// row that closes a multi-row frame, two results go into the two-entry queue
// between the row window and the stencil unit, and ready is low in between.
// Reset clears the row window, the queue and the output register.
// When out_row stalls, the output register and the queue hold results and
// in_row deasserts ready once the queue is full.
module life_cellular_automaton_row_step #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lcrs_in_if.sink                      in_row,
  lcrs_out_if.source                   out_row,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lcrs_pkg::COLS_W-1:0]  cfg_data
);

  logic [lcrs_pkg::COLS_W-1:0] active_columns_r, active_columns_nxt;
  lcrs_pkg::push_ctl_t         push;
  lcrs_pkg::push_ctl_t         head;
  logic [3*MAX_COLUMNS-1:0]    push_rows;
  logic [3*MAX_COLUMNS-1:0]    head_rows;
  logic                        space;
  logic                        pop;

  assign cfg_ready = 1'b1;
  assign active_columns_nxt = (cfg_valid && cfg_ready) ? cfg_data : active_columns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_columns_r <= lcrs_pkg::COLS_RESET;
    end else begin
      active_columns_r <= active_columns_nxt;
    end
  end

  lcrs_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_row    (in_row),
    .space     (space),
    .push      (push),
    .push_rows (push_rows)
  );

  lcrs_queue #(.WIDTH(3*MAX_COLUMNS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rows (push_rows),
    .space     (space),
    .head      (head),
    .head_rows (head_rows),
    .pop       (pop)
  );

  lcrs_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .active_columns (active_columns_r),
    .head           (head),
    .head_rows      (head_rows),
    .pop            (pop),
    .out_row        (out_row)
  );

endmodule
